>>> rtl/rgb_to_hsv_pixel_top_defines.svh
// Assertion macros shared by the RGB to HSV converter RTL.
`ifndef RGB_TO_HSV_PIXEL_TOP_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_TOP_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define RHSV_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define RHSV_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/rhsv_pkg.sv
// Types and constants shared by the RGB to HSV converter modules.
package rhsv_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned HUE_W       = 15;
    localparam int unsigned SAT_W       = 13;
    localparam int unsigned DIVIDEND_W  = 20;
    localparam int unsigned QUOT_W      = 13;
    localparam int unsigned RECIP_SHIFT = 20;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
    localparam int unsigned LUT_DEPTH   = 1 << CHAN_W;

    localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
    localparam logic [SAT_W-1:0] SAT_ONE    = 13'd4096;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_t;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // Result of the channel compare stage.
    typedef struct packed {
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] diff;
        logic [CHAN_W-1:0] mag;
        logic              neg;
        sector_t           sector;
    } front_t;

    // Stage enables of one divider.
    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } div_ctl_t;

endpackage

>>> rtl/rgb_to_hsv_pixel_top.sv
// RGB to HSV converter: one 24-bit RGB pixel word in, one hue/saturation/value word out.
//
// The converter takes one pixel word per clock while the output side is not
// stalled, and returns one HSV word per pixel, in order. The five stages are:
// channel compare, reciprocal table lookup, reciprocal multiply, quotient
// correction, and hue assembly into the output register. The two quotients
// (saturation = (max-min)*4096/max and the hue
// fraction 3840*|numerator|/(max-min)) each run through their own copy of the
// divider, so neither is shared and the rate stays at one pixel per cycle.
// Every stage holds its own valid bit and advances whenever the stage after it
// is empty or moving, so bubbles close up and a stall on the output holds
// every word in place. Brightness is the largest channel; ties pick red, then
// green, then blue for the hue sector. A black pixel gives zero hue and
// saturation, and a grey pixel gives zero hue.
module rgb_to_hsv_pixel_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pix_valid,
    output logic           pix_ready,
    input  rhsv_pkg::pixel_t pix,
    output logic           hsv_valid,
    input  logic           hsv_ready,
    output rhsv_pkg::hsv_t hsv
);

`include "rgb_to_hsv_pixel_top_defines.svh"

    // Side data that rides along with the divider stages.
    typedef struct packed {
        logic [rhsv_pkg::CHAN_W-1:0] hi;
        logic                        grey;
        logic                        neg;
        rhsv_pkg::sector_t           sector;
    } side_t;

    logic v1_reg, va_reg, vb_reg, vc_reg, vo_reg;
    logic en_1, en_a, en_b, en_c, en_o;

    // Each stage moves when it is empty or the stage after it moves.
    assign en_o      = !vo_reg || hsv_ready;
    assign en_c      = !vc_reg || en_o;
    assign en_b      = !vb_reg || en_c;
    assign en_a      = !va_reg || en_b;
    assign en_1      = !v1_reg || en_a;
    assign pix_ready = en_1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en_1) v1_reg <= pix_valid;
            if (en_a) va_reg <= v1_reg;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
            if (en_o) vo_reg <= vc_reg;
        end
    end

    // Stage one: channel compare.
    rhsv_pkg::front_t front;

    rhsv_front u_front (
        .clk   (clk),
        .en    (en_1),
        .pix   (pix),
        .front (front)
    );

    // Dividends: diff * 4096 for saturation, |num| * 3840 for the hue fraction.
    logic [rhsv_pkg::DIVIDEND_W-1:0] sat_n, hue_n;
    rhsv_pkg::div_ctl_t              div_ctl;
    logic [rhsv_pkg::QUOT_W-1:0]     sat_q, hue_q;

    assign sat_n = {front.diff, 12'd0};
    assign hue_n = {front.mag, 12'd0} - {4'd0, front.mag, 8'd0};

    assign div_ctl.en_a = en_a;
    assign div_ctl.en_b = en_b;
    assign div_ctl.en_c = en_c;

    rhsv_div u_sat_div (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (sat_n),
        .divisor  (front.hi),
        .quotient (sat_q)
    );

    rhsv_div u_hue_div (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (hue_n),
        .divisor  (front.diff),
        .quotient (hue_q)
    );

    side_t side_1, side_a_reg, side_b_reg, side_c_reg;

    assign side_1.hi     = front.hi;
    assign side_1.grey   = (front.diff == '0);
    assign side_1.neg    = front.neg;
    assign side_1.sector = front.sector;

    always_ff @(posedge clk)
    begin
        if (en_a) side_a_reg <= side_1;
        if (en_b) side_b_reg <= side_a_reg;
        if (en_c) side_c_reg <= side_b_reg;
    end

    // Output stage: sector offset plus signed fraction, wrapped into 0..23039 (1/64 degree units, below 360).
    logic [rhsv_pkg::HUE_W-1:0]   base;
    logic signed [rhsv_pkg::HUE_W:0] hue_sum;
    logic signed [rhsv_pkg::HUE_W:0] frac;
    rhsv_pkg::hsv_t               hsv_reg, hsv_next;

    always_comb
    begin
        case (side_c_reg.sector)
            rhsv_pkg::SECT_GREEN: base = rhsv_pkg::HUE_SECTOR;
            rhsv_pkg::SECT_BLUE:  base = rhsv_pkg::HUE_W'({rhsv_pkg::HUE_SECTOR, 1'b0});
            default:              base = '0;
        endcase
        frac    = $signed({3'd0, hue_q});
        if (side_c_reg.neg)
        begin
            frac = -frac;
        end
        hue_sum = $signed({1'b0, base}) + frac;
        if (hue_sum < 0)
        begin
            hue_sum = hue_sum + $signed({1'b0, rhsv_pkg::HUE_FULL});
        end
        hsv_next.brightness = side_c_reg.hi;
        hsv_next.saturation = (side_c_reg.hi == '0) ? '0 : sat_q;
        hsv_next.hue        = side_c_reg.grey ? '0 : hue_sum[rhsv_pkg::HUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            hsv_reg <= hsv_next;
        end
    end

    assign hsv_valid = vo_reg;
    assign hsv       = hsv_reg;

    `RHSV_ASSERT_IMPLY(a_sat_range, hsv_valid, hsv.saturation <= rhsv_pkg::SAT_ONE,
        "saturation above one")
    `RHSV_ASSERT_IMPLY(a_hue_range, hsv_valid, hsv.hue < rhsv_pkg::HUE_FULL,
        "hue at or above 360 degrees")
    `RHSV_ASSERT_IMPLY(a_black, hsv_valid && hsv.brightness == '0,
        hsv.hue == '0 && hsv.saturation == '0, "black pixel with nonzero hue or saturation")
    `RHSV_ASSERT_IMPLY(a_grey, hsv_valid && hsv.saturation == '0, hsv.hue == '0,
        "zero saturation with nonzero hue")

endmodule

>>> rtl/rhsv_front.sv
// Channel compare stage: maximum, spread, hue sector and hue numerator.
module rhsv_front (
    input  logic            clk,
    input  logic            en,
    input  rhsv_pkg::pixel_t pix,
    output rhsv_pkg::front_t front
);

    rhsv_pkg::front_t front_reg;
    rhsv_pkg::front_t front_next;
    logic [rhsv_pkg::CHAN_W-1:0] lo;
    logic signed [rhsv_pkg::CHAN_W:0] num;

    always_comb
    begin
        front_next = '0;
        // Red wins ties over green, green wins over blue.
        if (pix.red >= pix.green && pix.red >= pix.blue)
        begin
            front_next.sector = rhsv_pkg::SECT_RED;
            front_next.hi     = pix.red;
            num = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
        end
        else if (pix.green >= pix.blue)
        begin
            front_next.sector = rhsv_pkg::SECT_GREEN;
            front_next.hi     = pix.green;
            num = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
        end
        else
        begin
            front_next.sector = rhsv_pkg::SECT_BLUE;
            front_next.hi     = pix.blue;
            num = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
        end
        lo = pix.red;
        if (pix.green < lo)
        begin
            lo = pix.green;
        end
        if (pix.blue < lo)
        begin
            lo = pix.blue;
        end
        front_next.diff = front_next.hi - lo;
        front_next.neg  = num[rhsv_pkg::CHAN_W];
        front_next.mag  = num[rhsv_pkg::CHAN_W] ? rhsv_pkg::CHAN_W'(-num)
                                                : num[rhsv_pkg::CHAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

>>> rtl/rhsv_div.sv
// Three-stage reciprocal divider: table lookup, multiply, one-step correction.
module rhsv_div (
    input  logic                             clk,
    input  rhsv_pkg::div_ctl_t               ctl,
    input  logic [rhsv_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [rhsv_pkg::CHAN_W-1:0]      divisor,
    output logic [rhsv_pkg::QUOT_W-1:0]      quotient
);

    localparam int unsigned RecipOne = 1 << rhsv_pkg::RECIP_SHIFT;
    localparam int unsigned PROD_W   = rhsv_pkg::DIVIDEND_W + rhsv_pkg::RECIP_W;
    localparam int unsigned REM_W    = rhsv_pkg::QUOT_W + rhsv_pkg::CHAN_W;

    logic [rhsv_pkg::RECIP_W-1:0] recip_lut [rhsv_pkg::LUT_DEPTH];

    // floor(2^20 / d); a zero divisor reads zero and its quotient is unused.
    for (genvar D = 0; D < rhsv_pkg::LUT_DEPTH; D++)
    begin : g_lut
        localparam int unsigned Divisor = (D == 0) ? 1 : D;
        localparam logic [rhsv_pkg::RECIP_W-1:0] RecipVal =
            (D == 0) ? '0 : rhsv_pkg::RECIP_W'(RecipOne / Divisor);
        assign recip_lut[D] = RecipVal;
    end

    logic [rhsv_pkg::DIVIDEND_W-1:0] a_n_reg, b_n_reg;
    logic [rhsv_pkg::CHAN_W-1:0]     a_d_reg, b_d_reg;
    logic [rhsv_pkg::RECIP_W-1:0]    a_r_reg;
    logic [rhsv_pkg::QUOT_W-1:0]     b_q_reg, b_q_next;
    logic [rhsv_pkg::QUOT_W-1:0]     c_q_reg, c_q_next;
    logic [PROD_W-1:0]               prod;
    logic [REM_W-1:0]                rem;

    // The estimate is the true quotient or one below it, since the dividend
    // stays below 2^20.
    assign prod     = PROD_W'(a_n_reg) * PROD_W'(a_r_reg);
    assign b_q_next = prod[rhsv_pkg::RECIP_SHIFT +: rhsv_pkg::QUOT_W];
    assign rem      = REM_W'(b_n_reg) - REM_W'(b_q_reg) * REM_W'(b_d_reg);
    assign c_q_next = (rem >= REM_W'(b_d_reg)) ? b_q_reg + 1'b1 : b_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en_a)
        begin
            a_n_reg <= dividend;
            a_d_reg <= divisor;
            a_r_reg <= recip_lut[divisor];
        end
        if (ctl.en_b)
        begin
            b_n_reg <= a_n_reg;
            b_d_reg <= a_d_reg;
            b_q_reg <= b_q_next;
        end
        if (ctl.en_c)
        begin
            c_q_reg <= c_q_next;
        end
    end

    assign quotient = c_q_reg;

endmodule
